>>> design/acc_alu_pkg.sv
// ----------------------------------------------------------------------------
// acc_alu_pkg: shared codes for the accumulator calculator
// Opcode and status codes carried on the request and result streams.
// ----------------------------------------------------------------------------
package acc_alu_pkg;

  typedef logic [2:0] opcode_t;
  typedef logic [1:0] status_t;

  // opcodes; codes 6 and 7 leave the accumulators untouched
  localparam opcode_t OP_ADD = 3'd0;
  localparam opcode_t OP_SUB = 3'd1;
  localparam opcode_t OP_MUL = 3'd2;
  localparam opcode_t OP_DIV = 3'd3;
  localparam opcode_t OP_REM = 3'd4;
  localparam opcode_t OP_POW = 3'd5;

  // result status codes
  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_DIVZ   = 2'd1;
  localparam status_t ST_SAT    = 2'd2;
  localparam status_t ST_BADREM = 2'd3;

endpackage

>>> design/accumulator_calculator_alu.sv
// Sequence, from accept to m_tvalid: add/sub go setup then commit; mul shift-adds
//   VALUE_WIDTH bits, div and remainder form VALUE_WIDTH+FRACTION_BITS quotient bits,
//   power chains multiplies; errors, negative rem dividends, reserved go to commit.
// Throughput: one request in flight; s_tready rises with m_tvalid, and a result
//   held by m_tready stalls the next request in its final state. Shared adder.
// Reset (rst, synchronous) clears both accumulators, the sequencer and tvalid.
// ----------------------------------------------------------------------------
// accumulator_calculator_alu: fixed-point accumulator calculator
// Add, subtract, multiply, divide, remainder and power on signed fixed-point
// values, saturating on overflow, with the prior accumulator reported.
// ----------------------------------------------------------------------------
module accumulator_calculator_alu #(
  parameter int VALUE_WIDTH     = 48,
  parameter int FRACTION_BITS   = 16,
  parameter int MAX_POWER_STEPS = 63
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // opcode[2:0], use_memory[3], left_operand, right_operand, zero pad
  input  logic [((2*VALUE_WIDTH+4+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // result_value, previous_value, status_code[1:0], zero pad
  output logic [((2*VALUE_WIDTH+2+7)/8)*8-1:0] m_tdata
);
  import acc_alu_pkg::*;

  localparam int W    = VALUE_WIDTH;
  localparam int WP1  = VALUE_WIDTH + 1;
  localparam int PW2  = 2 * VALUE_WIDTH;
  localparam int DLEN = VALUE_WIDTH + FRACTION_BITS;
  localparam int ODW  = ((2*VALUE_WIDTH+2+7)/8)*8;
  localparam int CW   = $clog2(DLEN + 1);
  localparam int PSW  = $clog2(MAX_POWER_STEPS + 1);

  localparam logic [W-1:0] MAX_POS   = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MIN_NEG   = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] ONE       = W'(1) << FRACTION_BITS;
  localparam logic [W-1:0] FRAC_MASK = ONE - W'(1);
  localparam logic [W-1:0] STEP_CAP  = W'(MAX_POWER_STEPS);

  typedef enum logic [2:0] {
    S_IDLE, S_SETUP, S_MUL, S_MUL_FIN, S_DIV, S_DIV_FIN, S_COMMIT
  } state_t;

  state_t           state;
  opcode_t          op;
  logic [W-1:0]     a, b;
  logic [W-1:0]     acc, prior;
  logic [W-1:0]     opnd_mag;
  logic [PW2-1:0]   prod;
  logic [W:0]       rem;
  logic [DLEN-1:0]  quo;
  logic             neg;
  logic [CW-1:0]    cnt;
  logic [PSW-1:0]   pleft;
  logic [W-1:0]     res;
  logic             sat;
  status_t          err;
  logic             nop;
  logic [W-1:0]     out_res, out_prev;
  status_t          out_stat;

  // magnitudes of the captured operands
  logic [W-1:0] a_mag, b_mag;
  assign a_mag = a[W-1] ? (W'(0) - a) : a;
  assign b_mag = b[W-1] ? (W'(0) - b) : b;

  // shared adder/subtractor, steered by the sequencer
  logic [W:0] au_x, au_y, au_sum;
  logic       au_sub;
  always_comb begin
    au_x   = '0;
    au_y   = '0;
    au_sub = 1'b0;
    case (state)
      S_SETUP: begin
        au_x   = {a[W-1], a};
        au_y   = {b[W-1], b};
        au_sub = (op == OP_SUB);
      end
      S_MUL: begin
        au_x = {1'b0, prod[PW2-1:W]};
        au_y = prod[0] ? {1'b0, opnd_mag} : '0;
      end
      S_DIV: begin
        au_x   = {rem[W-1:0], quo[DLEN-1]};
        au_y   = {1'b0, opnd_mag};
        au_sub = 1'b1;
      end
      default: begin
      end
    endcase
  end
  assign au_sum = au_x + (au_sub ? ~au_y : au_y) + WP1'(au_sub);

  // add/sub overflow and saturated value
  logic         as_ovf;
  logic [W-1:0] as_val;
  assign as_ovf = au_sum[W] ^ au_sum[W-1];
  assign as_val = as_ovf ? (a[W-1] ? MIN_NEG : MAX_POS) : au_sum[W-1:0];

  // power step count: ceil(right) - 1, capped, zero when right <= 1
  logic [W-1:0]   ceil_m1;
  logic [PSW-1:0] steps;
  assign ceil_m1 = (b >> FRACTION_BITS) + W'((b & FRAC_MASK) != '0) - W'(1);
  always_comb begin
    if (b[W-1] || (b <= ONE)) begin
      steps = '0;
    end else if (ceil_m1 > STEP_CAP) begin
      steps = PSW'(MAX_POWER_STEPS);
    end else begin
      steps = ceil_m1[PSW-1:0];
    end
  end

  // product scaling and saturation
  logic [PW2-1:0] mq;
  logic [W-1:0]   sat_edge, m_val, d_val;
  logic           m_sat, d_sat;
  assign sat_edge = neg ? MIN_NEG : MAX_POS;
  assign mq       = prod >> FRACTION_BITS;
  assign m_sat    = mq > PW2'(sat_edge);
  assign m_val    = m_sat ? sat_edge : (neg ? (W'(0) - mq[W-1:0]) : mq[W-1:0]);

  // quotient saturation
  assign d_sat = quo > DLEN'(sat_edge);
  assign d_val = d_sat ? sat_edge : (neg ? (W'(0) - quo[W-1:0]) : quo[W-1:0]);

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = ODW'({out_stat, out_prev, out_res});

  // sequencer, datapath registers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      acc      <= '0;
      prior    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // drop a taken result unless a new one is committed this cycle
      if (m_tvalid && m_tready && (state != S_COMMIT)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        // capture the request
        S_IDLE: begin
          if (s_tvalid) begin
            op    <= s_tdata[2:0];
            a     <= s_tdata[3] ? acc : s_tdata[4 +: W];
            b     <= s_tdata[4+W +: W];
            err   <= ST_OK;
            sat   <= 1'b0;
            nop   <= 1'b0;
            state <= S_SETUP;
          end
        end
        // decode the operation and load the iterative unit
        S_SETUP: begin
          cnt <= '0;
          rem <= '0;
          case (op)
            OP_ADD, OP_SUB: begin
              res   <= as_val;
              sat   <= as_ovf;
              state <= S_COMMIT;
            end
            OP_MUL: begin
              opnd_mag <= b_mag;
              prod     <= {W'(0), a_mag};
              neg      <= a[W-1] ^ b[W-1];
              pleft    <= PSW'(1);
              state    <= S_MUL;
            end
            OP_DIV: begin
              if (b == '0) begin
                err   <= ST_DIVZ;
                state <= S_COMMIT;
              end else begin
                opnd_mag <= b_mag;
                quo      <= DLEN'(a_mag) << FRACTION_BITS;
                neg      <= a[W-1] ^ b[W-1];
                state    <= S_DIV;
              end
            end
            OP_REM: begin
              if ((b == '0) || b[W-1]) begin
                err   <= ST_BADREM;
                state <= S_COMMIT;
              end else if (a[W-1]) begin
                res   <= a;
                state <= S_COMMIT;
              end else begin
                opnd_mag <= b;
                quo      <= DLEN'(a);
                state    <= S_DIV;
              end
            end
            OP_POW: begin
              res <= a;
              if (steps == '0) begin
                state <= S_COMMIT;
              end else begin
                opnd_mag <= a_mag;
                prod     <= {W'(0), a_mag};
                neg      <= 1'b0;
                pleft    <= steps;
                state    <= S_MUL;
              end
            end
            default: begin
              nop   <= 1'b1;
              state <= S_COMMIT;
            end
          endcase
        end
        // shift-add one multiplier bit
        S_MUL: begin
          prod <= {au_sum, prod[W-1:1]};
          cnt  <= cnt + CW'(1);
          if (cnt == CW'(W - 1)) begin
            state <= S_MUL_FIN;
          end
        end
        // scale, saturate, and chain the next power step
        S_MUL_FIN: begin
          if ((op == OP_POW) && !m_sat && (pleft != PSW'(1))) begin
            pleft <= pleft - PSW'(1);
            prod  <= {W'(0), mq[W-1:0]};
            neg   <= (neg && (mq[W-1:0] != '0)) ^ a[W-1];
            cnt   <= '0;
            state <= S_MUL;
          end else begin
            res   <= m_val;
            sat   <= m_sat;
            state <= S_COMMIT;
          end
        end
        // restoring division, one quotient bit
        S_DIV: begin
          rem <= au_sum[W] ? au_x : au_sum;
          quo <= {quo[DLEN-2:0], ~au_sum[W]};
          cnt <= cnt + CW'(1);
          if (cnt == CW'(DLEN - 1)) begin
            state <= S_DIV_FIN;
          end
        end
        S_DIV_FIN: begin
          if (op == OP_REM) begin
            res <= rem[W-1:0];
          end else begin
            res <= d_val;
            sat <= d_sat;
          end
          state <= S_COMMIT;
        end
        // update the accumulators once the output register is free
        S_COMMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
            if (nop) begin
              out_res  <= acc;
              out_prev <= prior;
              out_stat <= ST_OK;
            end else if (err != ST_OK) begin
              prior    <= acc;
              out_res  <= acc;
              out_prev <= acc;
              out_stat <= err;
            end else begin
              prior    <= acc;
              acc      <= res;
              out_res  <= res;
              out_prev <= acc;
              out_stat <= sat ? ST_SAT : ST_OK;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // one request at a time: an accept closes the input until the result is made
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request accepted while busy");

  // error results carry the unchanged accumulator in both value fields
  a_error_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && ((out_stat == ST_DIVZ) || (out_stat == ST_BADREM)))
      |-> (out_res == out_prev))
    else $error("error result does not hold the accumulator");

  // a saturated result is one of the two range limits
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (out_stat == ST_SAT)) |-> ((out_res == MAX_POS) || (out_res == MIN_NEG)))
    else $error("saturated result off the range limits");

  // a fresh successful result becomes the accumulator
  a_acc_follow: assert property (@(posedge clk) disable iff (rst)
    (state == S_COMMIT && (!m_tvalid || m_tready) && !nop && (err == ST_OK))
      |=> (acc == out_res))
    else $error("accumulator does not follow the result");
`endif

endmodule
